// ===== hw/rtl/dcc_bwg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_bwg_pkg
// Shared types and constants of the DCC bit waveform generator.
// ----------------------------------------------------------------------------
package dcc_bwg_pkg;

  // Field widths of the request and response channels
  localparam int CmdW    = 2;
  localparam int IdxW    = 3;
  localparam int ByteW   = 8;
  localparam int LenW    = 4;
  localparam int HalfW   = 16;
  localparam int CfgIdxW = 1;

  // Request commands
  localparam logic [CmdW-1:0] CmdWrite = 2'd0;
  localparam logic [CmdW-1:0] CmdStart = 2'd1;
  localparam logic [CmdW-1:0] CmdTick  = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgHalfOne  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgHalfZero = 1'd1;

  // Reset half-periods in ticks
  localparam logic [HalfW-1:0] ResetHalfOne  = 16'd852;
  localparam logic [HalfW-1:0] ResetHalfZero = 16'd1617;

  // Most significant bit position of a packet byte
  localparam logic [2:0] BitTop = 3'd7;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [IdxW-1:0]  byte_index;
    logic [ByteW-1:0] byte_value;
    logic [LenW-1:0]  send_length;
  } req_t;

  typedef struct packed {
    logic signal_level;
    logic sending;
  } rsp_t;

endpackage

// ===== hw/rtl/dcc_bwg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_bwg_if
// Valid/ready channels for requests into and responses out of the generator.
// ----------------------------------------------------------------------------
interface dcc_bwg_req_if
  import dcc_bwg_pkg::*;
  ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dcc_bwg_rsp_if
  import dcc_bwg_pkg::*;
  ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/dcc_bwg_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_bwg_ram
// Generic single-write, single-read RAM with registered read data.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module dcc_bwg_ram #(
  parameter int Width = 8,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/dcc_bit_waveform_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_bit_waveform_generator_unit
// DCC square wave generator: packet bytes go to a small RAM, a start request
// sends them MSB first, one full wave per bit, one/zero half-periods taken
// from the configuration registers. Tick requests advance the wave timer.
//
//   Channel   Dir  Payload                                      Handshake
//   req       in   cmd, byte_index, byte_value, send_length     valid/ready
//   rsp       out  signal_level, sending                        valid/ready
//   cfg       in   cfg_idx_i, cfg_wdata_i                       cfg_we_i
//
// One request per cycle while ready is high; state updates at the accepting
// edge and its single response is registered, valid from the cycle after
// acceptance unless an older one waits. The byte in flight is read ahead from
// packet RAM at the address byte_pos will hold, bypassing a same-cycle write;
// a start resolves its first bit from that read in the following cycle.
// Reset clears all control state; packet RAM contents are undefined until
// written and get no clearing pass.
// A two-entry response buffer keeps req.ready high while one response waits.
// ----------------------------------------------------------------------------
module dcc_bit_waveform_generator_unit
  import dcc_bwg_pkg::*;
#(
  parameter int MAX_BYTES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  dcc_bwg_req_if.sink        req,
  dcc_bwg_rsp_if.source      rsp,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [HalfW-1:0]   cfg_wdata_i
);

  localparam int AddrW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int PosW  = $clog2(MAX_BYTES + 1);
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_BYTES);

  // Configuration registers
  logic [HalfW-1:0] half_one_q, half_zero_q;

  // Send state
  logic [PosW-1:0]  send_len_q, send_len_d;
  logic [PosW-1:0]  byte_pos_q, byte_pos_d;
  logic [2:0]       bit_pos_q, bit_pos_d;
  logic [HalfW-1:0] tick_q, tick_d;
  logic [HalfW-1:0] compare_q, compare_d;
  logic [HalfW-1:0] alt_q, alt_d;
  logic             level_q, level_d;
  logic             pend_q, pend_d;

  // Packet RAM access
  logic             wr_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [ByteW-1:0] rd_data, pkt_byte;
  logic             fwd_hit_q;
  logic [ByteW-1:0] fwd_data_q;

  // Response buffer
  logic out_valid_q, skid_valid_q;
  rsp_t out_q, skid_q, rsp_new;

  logic             in_acc, out_take;
  logic [PosW-1:0]  len_sat;
  logic [HalfW:0]   tick_nxt;
  logic [HalfW-1:0] compare_eff;
  logic             sending_now, bit_sel;

  assign in_acc   = req.valid && req.ready;
  assign out_take = out_valid_q && rsp.ready;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_one_q  <= ResetHalfOne;
      half_zero_q <= ResetHalfZero;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgHalfOne:  half_one_q  <= cfg_wdata_i;
        CfgHalfZero: half_zero_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Packet RAM: write on request, read ahead at next byte position
  assign wr_en   = in_acc && (req.data.cmd == CmdWrite)
                   && (int'(req.data.byte_index) < MAX_BYTES);
  assign wr_addr = AddrW'(req.data.byte_index);
  assign rd_addr = (byte_pos_d < MaxPos) ? byte_pos_d[AddrW-1:0] : '0;

  dcc_bwg_ram #(
    .Width (ByteW),
    .Depth (MAX_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (req.data.byte_value),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Bypass a write that hits the address read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else begin
      fwd_hit_q <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= req.data.byte_value;
  end

  assign pkt_byte = fwd_hit_q ? fwd_data_q : rd_data;

  // First bit of a fresh start is settled from byte 0 in the cycle after the start
  assign compare_eff = (pend_q && !pkt_byte[BitTop]) ? alt_q : compare_q;

  assign len_sat     = (int'(req.data.send_length) > MAX_BYTES) ? MaxPos
                       : PosW'(req.data.send_length);
  assign tick_nxt    = {1'b0, tick_q} + (HalfW+1)'(1);
  assign sending_now = byte_pos_q < send_len_q;
  assign bit_sel     = pkt_byte[bit_pos_q];

  // Request processing
  always_comb begin
    send_len_d = send_len_q;
    byte_pos_d = byte_pos_q;
    bit_pos_d  = bit_pos_q;
    tick_d     = tick_q;
    level_d    = level_q;
    compare_d  = compare_eff;
    alt_d      = alt_q;
    pend_d     = 1'b0;
    if (in_acc) begin
      case (req.data.cmd)
        CmdStart: begin
          send_len_d = len_sat;
          byte_pos_d = '0;
          compare_d  = half_one_q;
          if (len_sat == '0) begin
            bit_pos_d = '0;
          end else begin
            bit_pos_d = BitTop - 3'd1;
            alt_d     = half_zero_q;
            pend_d    = 1'b1;
          end
        end
        CmdTick: begin
          if (tick_nxt >= {1'b0, compare_eff}) begin
            tick_d  = '0;
            level_d = ~level_q;
            // rising edge: pick the next bit's half-period
            if (!level_q) begin
              if (sending_now) begin
                compare_d = bit_sel ? half_one_q : half_zero_q;
                if (bit_pos_q != '0) begin
                  bit_pos_d = bit_pos_q - 3'd1;
                end else begin
                  byte_pos_d = byte_pos_q + PosW'(1);
                  bit_pos_d  = BitTop;
                end
              end else begin
                compare_d = half_one_q;
              end
            end
          end else begin
            tick_d = tick_nxt[HalfW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_len_q <= '0;
      byte_pos_q <= '0;
      bit_pos_q  <= '0;
      tick_q     <= '0;
      compare_q  <= ResetHalfOne;
      level_q    <= 1'b0;
      pend_q     <= 1'b0;
    end else begin
      send_len_q <= send_len_d;
      byte_pos_q <= byte_pos_d;
      bit_pos_q  <= bit_pos_d;
      tick_q     <= tick_d;
      compare_q  <= compare_d;
      level_q    <= level_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    alt_q <= alt_d;
  end

  // Response buffer: main register plus skid entry
  assign rsp_new.signal_level = level_d;
  assign rsp_new.sending      = byte_pos_d < send_len_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_take) begin
        skid_q <= rsp_new;
      end else begin
        out_q <= rsp_new;
      end
    end
  end

  assign req.ready = !skid_valid_q;
  assign rsp.valid = out_valid_q;
  assign rsp.data  = out_q;

  // Checks
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a response while the main register is empty");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_pos_q <= send_len_q)
    else $error("byte position ran past the send length");

  a_pend_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |=> !pend_q || $past(in_acc && req.data.cmd == CmdStart))
    else $error("first-bit resolution lingered past one cycle");

  a_pend_at_byte0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (byte_pos_q == '0) && (send_len_q != '0))
    else $error("first-bit resolution outside a fresh send");

  a_idle_bitpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (send_len_q == '0) |-> (bit_pos_q == '0))
    else $error("bit position moved with nothing to send");

endmodule
